/* design/nnis_pkg.sv */
// Shared types, constants and command structs of the nearest-neighbor image scaler.
`timescale 1ns / 1ps
package nnis_pkg;

	// Defaults of the top-level parameters.
	localparam int MAX_WIDTH_DEF       = 512;
	localparam int MAX_HEIGHT_DEF      = 512;
	localparam int SCALE_FRAC_BITS_DEF = 16;

	// Fixed field widths.
	localparam int COLOR_W = 8;
	localparam int SIZE_W  = 10;
	localparam int DIM_W   = 17;
	localparam int PIX_W   = 3 * COLOR_W;
	localparam int SCALE_W = 24;
	localparam int IDX_W   = 2 * SIZE_W;

	localparam logic [DIM_W-1:0]   DIM_MAX     = '1;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_PIXEL     = 2'd0,
		ST_NO_MORE   = 2'd1,
		ST_UNSUP     = 2'd2,
		ST_NOT_READY = 2'd3
	} status_t;

	// Request kinds.
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_FETCH = 1'b1;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SIZE,
		S_DECIDE,
		S_DIVC,
		S_DIVR,
		S_ADDR,
		S_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic size;
		logic decide;
		logic div_start;
		logic div_row;
		logic latch_sx;
		logic latch_sy;
		logic addr;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		status_t dec_status;
		logic    out_free;
		logic    div_done;
	} sts_t;

endpackage

/* design/nearest_neighbor_image_scaler_top.sv */
// Top level of the nearest-neighbor image scaler.
// A load request (req_type 0) stores one source pixel in raster order; frame_start on a
// load restarts the frame and captures its size and encoding. A fetch request (req_type 1)
// returns one result: the next pixel of the resized image, or a status of no more pixels,
// unsupported encoding or load not complete. A fetch that yields a pixel uses the shared
// one-bit-per-cycle divider, which works out the source column and then the source row.
// One request is worked on at a time, and the result register lets the next request enter
// while a result waits. The frame store holds MAX_WIDTH * MAX_HEIGHT pixels, needs no
// clearing pass, and source pixels beyond its depth read as zero. The scale register may
// be written only while no request is in progress.
`timescale 1ns / 1ps
module nearest_neighbor_image_scaler_top #(
	parameter int MAX_WIDTH       = nnis_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT      = nnis_pkg::MAX_HEIGHT_DEF,
	parameter int SCALE_FRAC_BITS = nnis_pkg::SCALE_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic                         frame_start,
	input  logic [nnis_pkg::COLOR_W-1:0] in_blue,
	input  logic [nnis_pkg::COLOR_W-1:0] in_green,
	input  logic [nnis_pkg::COLOR_W-1:0] in_red,
	input  logic [nnis_pkg::SIZE_W-1:0]  src_width,
	input  logic [nnis_pkg::SIZE_W-1:0]  src_height,
	input  logic                         is_bgr8,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [nnis_pkg::COLOR_W-1:0] out_blue,
	output logic [nnis_pkg::COLOR_W-1:0] out_green,
	output logic [nnis_pkg::COLOR_W-1:0] out_red,
	output logic [nnis_pkg::DIM_W-1:0]   out_col,
	output logic [nnis_pkg::DIM_W-1:0]   out_row,
	output logic [nnis_pkg::DIM_W-1:0]   out_width,
	output logic [nnis_pkg::DIM_W-1:0]   out_height,
	output logic                         last_pixel,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [nnis_pkg::SCALE_W-1:0] cfg_data
);

	import nnis_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

	cmd_t cmd;
	sts_t sts;

	// The scale register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	nnis_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.req_type(req_type),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	nnis_dpath #(
		.DEPTH(DEPTH),
		.FRAC (SCALE_FRAC_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.frame_start(frame_start),
		.in_blue    (in_blue),
		.in_green   (in_green),
		.in_red     (in_red),
		.src_width  (src_width),
		.src_height (src_height),
		.is_bgr8    (is_bgr8),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.status     (status),
		.out_blue   (out_blue),
		.out_green  (out_green),
		.out_red    (out_red),
		.out_col    (out_col),
		.out_row    (out_row),
		.out_width  (out_width),
		.out_height (out_height),
		.last_pixel (last_pixel)
	);

endmodule

/* design/nnis_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module nnis_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 262144,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/nnis_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module nnis_div #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CW = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             qbit;
	logic [DEN_W:0]   rem_sub;

	// One trial subtraction of the shifted remainder.
	always_comb begin
		rem_sh  = {rem_q, quo_q[NUM_W-1]};
		qbit    = (rem_sh >= {1'b0, den_q});
		rem_sub = rem_sh - {1'b0, den_q};
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* design/nnis_ctrl.sv */
// Controller state machine that sequences load and fetch requests.
`timescale 1ns / 1ps
module nnis_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          req_type,
	output logic          in_stall,
	input  nnis_pkg::sts_t sts,
	output nnis_pkg::cmd_t cmd
);

	import nnis_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (req_type == REQ_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						state_d = S_SIZE;
					end
				end
			end
			S_SIZE: begin
				cmd.size = 1'b1;
				state_d  = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.dec_status == ST_PIXEL) begin
					cmd.decide    = 1'b1;
					cmd.div_start = 1'b1;
					state_d       = S_DIVC;
				end else if (sts.out_free) begin
					cmd.decide = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_DIVC: begin
				if (sts.div_done) begin
					cmd.latch_sx  = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_row   = 1'b1;
					state_d       = S_DIVR;
				end
			end
			S_DIVR: begin
				cmd.div_row = 1'b1;
				if (sts.div_done) begin
					cmd.latch_sy = 1'b1;
					state_d      = S_ADDR;
				end
			end
			S_ADDR: begin
				cmd.addr = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* design/nnis_dpath.sv */
// Datapath: frame store, held frame data, scan position, divider and result register.
`timescale 1ns / 1ps
module nnis_dpath #(
	parameter int DEPTH = nnis_pkg::MAX_WIDTH_DEF * nnis_pkg::MAX_HEIGHT_DEF,
	parameter int FRAC  = nnis_pkg::SCALE_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nnis_pkg::cmd_t                cmd,
	output nnis_pkg::sts_t                sts,
	input  logic                          cfg_valid,
	input  logic [nnis_pkg::SCALE_W-1:0]  cfg_data,
	input  logic                          frame_start,
	input  logic [nnis_pkg::COLOR_W-1:0]  in_blue,
	input  logic [nnis_pkg::COLOR_W-1:0]  in_green,
	input  logic [nnis_pkg::COLOR_W-1:0]  in_red,
	input  logic [nnis_pkg::SIZE_W-1:0]   src_width,
	input  logic [nnis_pkg::SIZE_W-1:0]   src_height,
	input  logic                          is_bgr8,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [1:0]                    status,
	output logic [nnis_pkg::COLOR_W-1:0]  out_blue,
	output logic [nnis_pkg::COLOR_W-1:0]  out_green,
	output logic [nnis_pkg::COLOR_W-1:0]  out_red,
	output logic [nnis_pkg::DIM_W-1:0]    out_col,
	output logic [nnis_pkg::DIM_W-1:0]    out_row,
	output logic [nnis_pkg::DIM_W-1:0]    out_width,
	output logic [nnis_pkg::DIM_W-1:0]    out_height,
	output logic                          last_pixel
);

	import nnis_pkg::*;

	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int NUM_W  = DIM_W + FRAC;
	localparam int PROD_W = SIZE_W + SCALE_W;

	// Held frame data and configuration.
	logic [SCALE_W-1:0] scale_q;
	logic [SIZE_W-1:0]  w_q;
	logic [SIZE_W-1:0]  h_q;
	logic               enc_q;
	logic [CNT_W-1:0]   total_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIM_W-1:0]   col_q;
	logic [DIM_W-1:0]   row_q;
	logic               done_q;
	logic [DIM_W-1:0]   ow_q;
	logic [DIM_W-1:0]   oh_q;
	logic [SIZE_W-1:0]  sx_q;
	logic [SIZE_W-1:0]  sy_q;
	logic               in_range_q;

	// Result register.
	logic               ovalid_q;
	status_t            ostatus_q;
	logic [PIX_W-1:0]   opix_q;
	logic [DIM_W-1:0]   ocol_q;
	logic [DIM_W-1:0]   orow_q;
	logic [DIM_W-1:0]   ow_out_q;
	logic [DIM_W-1:0]   oh_out_q;
	logic               olast_q;

	logic [IDX_W-1:0]   tot_prod;
	logic [CNT_W-1:0]   tot_new;
	logic [CNT_W-1:0]   tot_eff;
	logic [CNT_W-1:0]   cnt_eff;
	logic               wr_en;
	logic [PROD_W-1:0]  prod_w;
	logic [PROD_W-1:0]  prod_h;
	logic [PROD_W-1:0]  sh_w;
	logic [PROD_W-1:0]  sh_h;
	logic [DIM_W-1:0]   ow_c;
	logic [DIM_W-1:0]   oh_c;
	logic               wrap;
	logic [DIM_W-1:0]   col_e;
	logic [DIM_W-1:0]   row_e;
	logic               end_c;
	status_t            dec_st;
	logic [NUM_W-1:0]   div_num;
	logic               div_done;
	logic [NUM_W-1:0]   div_quo;
	logic [SIZE_W-1:0]  coord_c;
	logic [IDX_W-1:0]   idx;
	logic [31:0]        idx32;
	logic [PIX_W-1:0]   rdata;
	logic               last_c;
	logic               out_free;
	logic [DIM_W:0]     col_inc;

	// Pixel count of a new frame, capped at the store depth.
	always_comb begin
		tot_prod = IDX_W'(src_width) * IDX_W'(src_height);
		tot_new  = (32'(tot_prod) > 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(tot_prod);
		tot_eff  = frame_start ? tot_new : total_q;
		cnt_eff  = frame_start ? '0 : cnt_q;
		wr_en    = cmd.load && (cnt_eff < tot_eff);
	end

	// Resized size, floor of size times scale, saturated.
	always_comb begin
		prod_w = PROD_W'(w_q) * PROD_W'(scale_q);
		prod_h = PROD_W'(h_q) * PROD_W'(scale_q);
		sh_w   = prod_w >> FRAC;
		sh_h   = prod_h >> FRAC;
		ow_c   = (sh_w > PROD_W'(DIM_MAX)) ? DIM_MAX : sh_w[DIM_W-1:0];
		oh_c   = (sh_h > PROD_W'(DIM_MAX)) ? DIM_MAX : sh_h[DIM_W-1:0];
	end

	// Fetch decision: row wrap after a scale change, then the status.
	always_comb begin
		wrap  = !done_q && (col_q >= ow_q);
		col_e = wrap ? '0 : col_q;
		row_e = wrap ? row_q + DIM_W'(1) : row_q;
		end_c = done_q || (ow_q == '0) || (oh_q == '0) || (row_e >= oh_q);
		if (!enc_q) begin
			dec_st = ST_UNSUP;
		end else if (cnt_q < total_q) begin
			dec_st = ST_NOT_READY;
		end else if (end_c) begin
			dec_st = ST_NO_MORE;
		end else begin
			dec_st = ST_PIXEL;
		end
	end

	// Source coordinate: quotient clamped to the last column or row.
	always_comb begin
		div_num = cmd.div_row ? {row_e, {FRAC{1'b0}}} : {col_e, {FRAC{1'b0}}};
		if (cmd.latch_sx) begin
			coord_c = (div_quo >= NUM_W'(w_q)) ? w_q - SIZE_W'(1) : div_quo[SIZE_W-1:0];
		end else begin
			coord_c = (div_quo >= NUM_W'(h_q)) ? h_q - SIZE_W'(1) : div_quo[SIZE_W-1:0];
		end
	end

	// Store index of the source pixel.
	always_comb begin
		idx   = IDX_W'(sy_q) * IDX_W'(w_q) + IDX_W'(sx_q);
		idx32 = 32'(idx);
	end

	always_comb begin
		last_c   = (col_q == ow_q - DIM_W'(1)) && (row_q == oh_q - DIM_W'(1));
		col_inc  = {1'b0, col_q} + (DIM_W + 1)'(1);
		out_free = !ovalid_q || !out_stall;
	end

	nnis_div #(
		.NUM_W(NUM_W),
		.DEN_W(SCALE_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (scale_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	nnis_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(cnt_eff[ADDR_W-1:0]),
		.wdata({in_red, in_green, in_blue}),
		.re   (cmd.addr),
		.raddr(idx32[ADDR_W-1:0]),
		.rdata(rdata)
	);

	// Control state: frame data, load count and scan position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			w_q     <= SIZE_W'(1);
			h_q     <= SIZE_W'(1);
			enc_q   <= 1'b0;
			total_q <= CNT_W'(1);
			cnt_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				scale_q <= cfg_data;
			end
			if (cmd.load) begin
				if (frame_start) begin
					w_q     <= src_width;
					h_q     <= src_height;
					enc_q   <= is_bgr8;
					total_q <= tot_new;
					col_q   <= '0;
					row_q   <= '0;
					done_q  <= 1'b0;
				end
				cnt_q <= wr_en ? cnt_eff + CNT_W'(1) : cnt_eff;
			end
			if (cmd.decide && (dec_st == ST_PIXEL || dec_st == ST_NO_MORE)) begin
				col_q <= col_e;
				row_q <= row_e;
				if (dec_st == ST_NO_MORE) begin
					done_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				if (last_c) begin
					done_q <= 1'b1;
				end else if (col_inc >= {1'b0, ow_q}) begin
					col_q <= '0;
					row_q <= row_q + DIM_W'(1);
				end else begin
					col_q <= col_inc[DIM_W-1:0];
				end
			end
		end
	end

	// Working registers of one fetch.
	always_ff @(posedge clk) begin
		if (cmd.size) begin
			ow_q <= ow_c;
			oh_q <= oh_c;
		end
		if (cmd.latch_sx) begin
			sx_q <= coord_c;
		end
		if (cmd.latch_sy) begin
			sy_q <= coord_c;
		end
		if (cmd.addr) begin
			in_range_q <= (idx32 < 32'(DEPTH));
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if ((cmd.decide && dec_st != ST_PIXEL) || cmd.emit) begin
			ovalid_q <= 1'b1;
		end else if (!out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.decide && dec_st != ST_PIXEL) begin
			ostatus_q <= dec_st;
			opix_q    <= '0;
			ocol_q    <= '0;
			orow_q    <= '0;
			olast_q   <= 1'b0;
			ow_out_q  <= (dec_st == ST_UNSUP) ? '0 : ow_q;
			oh_out_q  <= (dec_st == ST_UNSUP) ? '0 : oh_q;
		end else if (cmd.emit) begin
			ostatus_q <= ST_PIXEL;
			opix_q    <= in_range_q ? rdata : '0;
			ocol_q    <= col_q;
			orow_q    <= row_q;
			olast_q   <= last_c;
			ow_out_q  <= ow_q;
			oh_out_q  <= oh_q;
		end
	end

	assign sts.dec_status = dec_st;
	assign sts.out_free   = out_free;
	assign sts.div_done   = div_done;

	assign out_valid  = ovalid_q;
	assign status     = ostatus_q;
	assign out_blue   = opix_q[COLOR_W-1:0];
	assign out_green  = opix_q[2*COLOR_W-1:COLOR_W];
	assign out_red    = opix_q[PIX_W-1:2*COLOR_W];
	assign out_col    = ocol_q;
	assign out_row    = orow_q;
	assign out_width  = ow_out_q;
	assign out_height = oh_out_q;
	assign last_pixel = olast_q;

endmodule

/* design/nnis_chk.sv */
// Port-level checker of the image scaler and its bind to the top level.
`timescale 1ns / 1ps
module nnis_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [1:0]                   status,
	input logic [nnis_pkg::DIM_W-1:0]   out_col,
	input logic [nnis_pkg::DIM_W-1:0]   out_row,
	input logic [nnis_pkg::DIM_W-1:0]   out_width,
	input logic [nnis_pkg::DIM_W-1:0]   out_height,
	input logic                         last_pixel
);

	import nnis_pkg::*;

	// A stalled result stays in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_col))
		else $error("stalled result changed");

	// Only a pixel result can close the frame.
	a_last_pix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_pixel |-> status == ST_PIXEL)
		else $error("last flag on a status result");

	// The last pixel sits in the bottom-right corner of the resized image.
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_pixel |->
			out_col == out_width - 17'd1 && out_row == out_height - 17'd1)
		else $error("last pixel not at the corner");

	// An unsupported frame reports no size.
	a_unsup: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_UNSUP |-> out_width == '0 && out_height == '0)
		else $error("size reported for an unsupported frame");

endmodule

bind nearest_neighbor_image_scaler_top nnis_chk u_nnis_chk (.*);

/* bench/nearest_neighbor_image_scaler_top_test.sv */
// Self-checking testbench for the nearest-neighbor image scaler top level.
`timescale 1ns / 1ps
module nearest_neighbor_image_scaler_top_test;
	import nnis_pkg::*;

	localparam int FRAC       = SCALE_FRAC_BITS_DEF;
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_LEN   = 400;
	localparam int SETTLE     = 100;
	localparam int ITEM_GOAL  = 1650;

	// One request as seen on the input channel.
	typedef struct packed {
		logic               kind;
		logic               fs;
		logic [COLOR_W-1:0] b;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] r;
		logic [SIZE_W-1:0]  w;
		logic [SIZE_W-1:0]  h;
		logic               bgr;
	} scaler_req_t;

	localparam int REQ_W = $bits(scaler_req_t);

	// One result as seen on the output channel.
	typedef struct packed {
		status_t            st;
		logic [COLOR_W-1:0] b;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] r;
		logic [DIM_W-1:0]   col;
		logic [DIM_W-1:0]   row;
		logic [DIM_W-1:0]   ow;
		logic [DIM_W-1:0]   oh;
		logic               last;
	} scaler_res_t;

	// Tracks the frame store and emit position, and holds the pixels still owed.
	class resize_scoreboard;
		logic [SCALE_W-1:0] scale;
		int unsigned        w_held, h_held, loaded, col, row;
		bit                 bgr_held, done;
		logic [PIX_W-1:0]   pixels[int];
		scaler_res_t        owed_q[$];
		int                 errors, n_pix, n_status;

		function new();
			scale    = SCALE_RESET;
			w_held   = 1;
			h_held   = 1;
			loaded   = 0;
			col      = 0;
			row      = 0;
			bgr_held = 0;
			done     = 0;
		endfunction

		function void set_scale(logic [SCALE_W-1:0] v);
			scale = v;
		endfunction

		function int unsigned resized(int unsigned sz);
			longint unsigned v;
			v = (longint'(sz) * longint'(scale)) >> FRAC;
			if (v > DIM_MAX)
				v = DIM_MAX;
			return int'(v);
		endfunction

		function int unsigned src_pos(int unsigned pos, int unsigned sz);
			longint unsigned s;
			s = (longint'(pos) << FRAC) / longint'(scale);
			if (s >= sz)
				s = sz - 1;
			return int'(s);
		endfunction

		// Advance the model by one accepted request.
		function void note_request(scaler_req_t q);
			scaler_res_t e;
			int unsigned ow, oh, sx, sy, idx;
			logic [PIX_W-1:0] px;
			e = '0;
			if (q.kind == REQ_LOAD) begin
				if (q.fs) begin
					w_held   = q.w;
					h_held   = q.h;
					bgr_held = q.bgr;
					loaded   = 0;
					col      = 0;
					row      = 0;
					done     = 0;
				end
				if (loaded < w_held * h_held) begin
					pixels[loaded] = {q.r, q.g, q.b};
					loaded++;
				end
				return;
			end
			if (!bgr_held) begin
				e.st = ST_UNSUP;
			end else begin
				ow   = resized(w_held);
				oh   = resized(h_held);
				e.ow = DIM_W'(ow);
				e.oh = DIM_W'(oh);
				if (loaded < w_held * h_held) begin
					e.st = ST_NOT_READY;
				end else begin
					if (!done && col >= ow) begin
						col = 0;
						row++;
					end
					if (done || ow == 0 || oh == 0 || row >= oh) begin
						done = 1;
						e.st = ST_NO_MORE;
					end else begin
						sx  = src_pos(col, w_held);
						sy  = src_pos(row, h_held);
						idx = sy * w_held + sx;
						px  = pixels.exists(idx) ? pixels[idx] : '0;
						e.st   = ST_PIXEL;
						{e.r, e.g, e.b} = px;
						e.col  = DIM_W'(col);
						e.row  = DIM_W'(row);
						e.last = (col == ow - 1 && row == oh - 1);
						if (e.last)
							done = 1;
						else if (col + 1 >= ow) begin
							col = 0;
							row++;
						end else
							col++;
					end
				end
			end
			owed_q.push_back(e);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// Compare one delivered result with the oldest one owed.
		task check_result(scaler_res_t got);
			scaler_res_t e;
			if (owed_q.size() == 0) begin
				report("result delivered with none outstanding");
				return;
			end
			e = owed_q.pop_front();
			if (e.st == ST_PIXEL)
				n_pix++;
			else
				n_status++;
			if (got != e)
				report($sformatf({"got/exp status %0d/%0d bgr %h/%h col %0d/%0d row %0d/%0d",
					" size %0dx%0d/%0dx%0d last %0b/%0b"}, got.st, e.st,
					{got.b, got.g, got.r}, {e.b, e.g, e.r}, got.col, e.col, got.row, e.row,
					got.ow, got.oh, e.ow, e.oh, got.last, e.last));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               req_type = 1'b0;
	logic               frame_start = 1'b0;
	logic [COLOR_W-1:0] in_blue = '0, in_green = '0, in_red = '0;
	logic [SIZE_W-1:0]  src_width = '0, src_height = '0;
	logic               is_bgr8 = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [COLOR_W-1:0] out_blue, out_green, out_red;
	logic [DIM_W-1:0]   out_col, out_row, out_width, out_height;
	logic               last_pixel;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [SCALE_W-1:0] cfg_data = '0;

	resize_scoreboard sb = new();
	int  n_sent, n_results, idle_cycles, n_cfg;
	bit  calm, held_off;

	always #1 clk = ~clk;

	nearest_neighbor_image_scaler_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
		.frame_start(frame_start), .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
		.src_width(src_width), .src_height(src_height), .is_bgr8(is_bgr8),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.out_blue(out_blue), .out_green(out_green), .out_red(out_red),
		.out_col(out_col), .out_row(out_row), .out_width(out_width),
		.out_height(out_height), .last_pixel(last_pixel),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Observe every handshake at the rising edge and run the watchdog.
	always @(posedge clk) begin : observe
		bit moved;
		moved = 0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_request({req_type, frame_start, in_blue, in_green, in_red,
					src_width, src_height, is_bgr8});
				moved = 1;
			end
			if (out_valid && !out_stall) begin
				sb.check_result({status_t'(status), out_blue, out_green, out_red, out_col,
					out_row, out_width, out_height, last_pixel});
				n_results++;
				moved = 1;
			end
			if (cfg_valid && cfg_ready) begin
				sb.set_scale(cfg_data);
				n_cfg++;
				moved = 1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Result side: random stalls, plus one long hold-off to back the block up.
	initial begin : receiver
		int n;
		@(posedge arst_n);
		forever begin
			if (!held_off && n_results >= 60) begin
				held_off = 1;
				repeat (HOLD_LEN) begin
					@(negedge clk);
					out_stall = 1'b1;
				end
			end
			n = calm ? 0 : $urandom_range(0, 5);
			repeat (n) begin
				@(negedge clk);
				out_stall = 1'b1;
			end
			@(negedge clk);
			out_stall = 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Offer one request and hold it until it is taken.
	task send(scaler_req_t q);
		int n;
		n = calm ? 0 : $urandom_range(0, 5);
		repeat (n) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		{req_type, frame_start, in_blue, in_green, in_red, src_width, src_height, is_bgr8} = q;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_sent++;
	endtask

	task load_px(bit fs, int w, int h, bit bgr);
		scaler_req_t q;
		q      = REQ_W'({$urandom, $urandom});
		q.kind = REQ_LOAD;
		q.fs   = fs;
		q.w    = SIZE_W'(w);
		q.h    = SIZE_W'(h);
		q.bgr  = bgr;
		send(q);
	endtask

	// Fetch with random filler in the unused fields; frame_start here is ignored.
	task fetch();
		scaler_req_t q;
		q      = REQ_W'({$urandom, $urandom});
		q.kind = REQ_FETCH;
		send(q);
	endtask

	task load_frame(int w, int h, bit bgr);
		load_px(1, w, h, bgr);
		repeat (w * h - 1)
			load_px(0, 0, 0, 0);
	endtask

	// Scale is written only once nothing is in flight.
	task write_scale(logic [SCALE_W-1:0] v);
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.owed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function logic [SCALE_W-1:0] pick_scale();
		case ($urandom_range(0, 9))
			0:       return SCALE_W'(1);
			1:       return '1;
			2:       return SCALE_W'($urandom_range(1, 65535));
			default: return SCALE_W'($urandom_range(8192, 200000));
		endcase
	endfunction

	// Directed cases first, then random frames.
	initial begin : stimulus
		int w, h, n, kind;
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Out of reset the encoding is not BGR8; a load with no frame start goes to pixel 0.
		calm = 1;
		fetch();
		load_px(0, 0, 0, 0);
		fetch();
		// Largest frame, only started: not ready, then its size saturates at full scale.
		load_px(1, 512, 512, 1);
		fetch();
		write_scale('1);
		fetch();
		load_px(1, 512, 512, 0);
		fetch();
		// Smallest scale collapses the image to nothing.
		write_scale(SCALE_W'(1));
		load_frame(2, 2, 1);
		fetch();
		write_scale(SCALE_RESET);
		load_px(1, 1, 1, 1);
		load_px(0, 7, 7, 0);
		fetch();
		fetch();
		fetch();
		load_frame(2, 2, 1);
		fetch();
		fetch();
		// Shrink the image mid-frame: emission must wrap or end early.
		write_scale(SCALE_W'(32768));
		fetch();
		fetch();
		calm = 0;

		while (n_sent < ITEM_GOAL) begin
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 2) == 0)
				write_scale(pick_scale());
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				// Noise: any size, barely loaded.
				load_px(1, $urandom_range(1, 512), $urandom_range(1, 512), 1'($urandom));
				repeat ($urandom_range(0, 3))
					load_px(0, 0, 0, 0);
				repeat ($urandom_range(1, 3))
					fetch();
			end else begin
				w = $urandom_range(1, 6);
				h = $urandom_range(1, 6);
				load_px(1, w, h, kind != 1);
				if (kind == 2 && w * h > 1) begin
					// Fetch while the load is still short of the full frame.
					repeat ($urandom_range(1, w * h - 1) - 1)
						load_px(0, 0, 0, 0);
					fetch();
					n = 0;
					while (sb.loaded < w * h)
						load_px(0, 0, 0, 0);
				end else begin
					repeat (w * h - 1)
						load_px(0, 0, 0, 0);
				end
				if ($urandom_range(0, 3) == 0)
					load_px(0, 0, 0, 0);
				n = sb.resized(w) * sb.resized(h);
				n = (n > 30 ? 30 : n) + $urandom_range(0, 2);
				if ($urandom_range(0, 5) == 0 && n > 2) begin
					repeat (n / 2)
						fetch();
					write_scale(pick_scale());
				end
				repeat (n)
					fetch();
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (sb.owed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
		$display("Covered %0d requests, %0d scale writes, %0d pixels and %0d status results.",
			n_sent, n_cfg, sb.n_pix, sb.n_status);
		$display("Mismatches: %0d", sb.errors);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
